// ----- design/tdr_pkg.sv -----
`default_nettype none

package tdr_pkg;

  localparam int TICK_W   = 64;
  localparam int CNT_W    = 32;
  localparam int DEB_W    = 13;
  localparam int TPM_W    = 20;
  localparam int WIN_W    = DEB_W + TPM_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;
  localparam int QDEPTH   = 2;

  localparam logic [DEB_W-1:0] DEB_RESET = 13'd50;
  localparam logic [TPM_W-1:0] TPM_RESET = 20'd1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_EN    = 2'd2;

  localparam logic [1:0] OUTCOME_REPORTED = 2'd0;
  localparam logic [1:0] OUTCOME_SILENT   = 2'd1;
  localparam logic [1:0] OUTCOME_BOUNCE   = 2'd2;

  // Classified input transaction as it travels through the queue
  typedef struct packed {
    logic              service;
    logic              hit;      // edge on a button that exists
    logic              button;
    logic [TICK_W-1:0] tick;
  } tdr_item_t;

endpackage

`default_nettype wire

// ----- design/tdr_front.sv -----
`default_nettype none

module tdr_front #(
  parameter int BUTTONS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic              in_button,
  input  wire logic [63:0]       in_tick,
  output logic                   q_push,
  output tdr_pkg::tdr_item_t     q_item,
  input  wire logic              q_ready
);
  import tdr_pkg::*;

  logic      item_valid_r;
  tdr_item_t item_r;

  assign in_ready = !item_valid_r || q_ready;
  assign q_push   = item_valid_r && q_ready;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.service <= in_action;
      item_r.hit     <= !in_action && (int'(in_button) < BUTTONS);
      item_r.button  <= in_button;
      item_r.tick    <= in_tick;
    end
  end

endmodule

`default_nettype wire

// ----- design/tdr_fifo.sv -----
`default_nettype none

module tdr_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tdr_pkg::tdr_item_t push_item,
  output logic                    ready,
  output logic                    valid,
  output tdr_pkg::tdr_item_t      head,
  input  wire logic               pop
);
  import tdr_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  tdr_item_t          mem [QDEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [PW:0]        count_r, count_nxt;

  assign ready = (count_r != (PW+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/tdr_back.sv -----
`default_nettype none

module tdr_back #(
  parameter int BUTTONS = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire tdr_pkg::tdr_item_t          q_head,
  output logic                             q_pop,
  input  wire logic [tdr_pkg::WIN_W-1:0]   window,
  input  wire logic                        report_en,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_button_id,
  output logic [1:0]                       out_outcome,
  output logic [31:0]                      out_sequence_res,
  output logic [63:0]                      out_press_tick,
  output logic [31:0]                      out_edge_count,
  output logic [31:0]                      out_press_count,
  output logic [31:0]                      out_bounce_count
);
  import tdr_pkg::*;

  localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  logic [BUTTONS-1:0] pending_r;
  logic [BUTTONS-1:0] have_press_r;
  logic [TICK_W-1:0]  edge_time_r  [BUTTONS];
  logic [TICK_W-1:0]  last_press_r [BUTTONS];
  logic [CNT_W-1:0]   edges_r      [BUTTONS];
  logic [CNT_W-1:0]   presses_r    [BUTTONS];
  logic [CNT_W-1:0]   bounces_r    [BUTTONS];
  logic [CNT_W-1:0]   seq_r, seq_nxt;

  logic              out_valid_r;
  logic              found;
  logic [BW-1:0]     sel, idx;
  logic              do_edge, do_service, bounce;
  logic [TICK_W-1:0] t, last, gap;
  logic [CNT_W-1:0]  edges_cur, presses_nxt, bounces_nxt;
  logic [1:0]        outcome;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // lowest pending button wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = BUTTONS - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        found = 1'b1;
        sel   = BW'(i);
      end
    end
  end

  always_comb begin
    idx         = q_head.service ? sel : BW'(q_head.button);
    do_edge     = q_pop && !q_head.service && q_head.hit;
    do_service  = q_pop && q_head.service && found;
    t           = edge_time_r[idx];
    last        = last_press_r[idx];
    gap         = t - last;
    bounce      = have_press_r[idx] && (t > last) && (gap < TICK_W'(window));
    edges_cur   = edges_r[idx];
    presses_nxt = presses_r[idx];
    bounces_nxt = bounces_r[idx];
    seq_nxt     = seq_r;
    if (bounce) begin
      bounces_nxt = bounces_r[idx] + 1'b1;
      outcome     = OUTCOME_BOUNCE;
    end else begin
      presses_nxt = presses_r[idx] + 1'b1;
      seq_nxt     = seq_r + 1'b1;
      outcome     = report_en ? OUTCOME_REPORTED : OUTCOME_SILENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= '0;
      have_press_r <= '0;
      seq_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        edge_time_r[i]  <= '0;
        last_press_r[i] <= '0;
        edges_r[i]      <= '0;
        presses_r[i]    <= '0;
        bounces_r[i]    <= '0;
      end
    end else begin
      if (do_edge) begin
        edges_r[idx] <= edges_cur + 1'b1;
        if (!pending_r[idx]) begin
          pending_r[idx]   <= 1'b1;
          edge_time_r[idx] <= q_head.tick;
        end
      end
      if (do_service) begin
        pending_r[idx] <= 1'b0;
        bounces_r[idx] <= bounces_nxt;
        presses_r[idx] <= presses_nxt;
        seq_r          <= seq_nxt;
        if (!bounce) begin
          last_press_r[idx] <= t;
          have_press_r[idx] <= 1'b1;
        end
      end
      if (do_service) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_service) begin
      out_button_id    <= idx[0];
      out_outcome      <= outcome;
      out_sequence_res <= seq_nxt;
      out_press_tick   <= t;
      out_edge_count   <= edges_cur;
      out_press_count  <= presses_nxt;
      out_bounce_count <= bounces_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/timestamp_debounce_event_reporter.sv -----
// An accepted service transaction passes the input register at the accepting
// edge, a queue entry, then the result register. Throughput: one transaction
// per cycle while the queue has room; the back end retires one queue entry
// per cycle whenever the result register is free or being drained.
// Reset (rst_n low, synchronous): all pending flags, timestamps and counters
// clear; registers return to debounce_ms 50, ticks_per_ms 1, report_enable 1.
`default_nettype none

module timestamp_debounce_event_reporter #(
  parameter int BUTTONS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic        in_button,
  input  wire logic [63:0] in_tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_button_id,
  output logic [1:0]       out_outcome,
  output logic [31:0]      out_sequence_res,
  output logic [63:0]      out_press_tick,
  output logic [31:0]      out_edge_count,
  output logic [31:0]      out_press_count,
  output logic [31:0]      out_bounce_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  import tdr_pkg::*;

  logic [DEB_W-1:0] debounce_ms_r;
  logic [TPM_W-1:0] ticks_per_ms_r;
  logic             report_en_r;
  logic [WIN_W-1:0] window_r;

  logic      q_push, q_ready, q_valid, q_pop;
  tdr_item_t q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r  <= DEB_RESET;
      ticks_per_ms_r <= TPM_RESET;
      report_en_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_data[DEB_W-1:0];
        REG_TICKS_PER_MS: ticks_per_ms_r <= cfg_data[TPM_W-1:0];
        REG_REPORT_EN:    report_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // lockout window, registered from the config registers; settles in the cycle after a register write
  always_ff @(posedge clk) begin
    window_r <= WIN_W'(debounce_ms_r) * WIN_W'(ticks_per_ms_r);
  end

  tdr_front #(.BUTTONS(BUTTONS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_button (in_button),
    .in_tick   (in_tick),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_ready   (q_ready)
  );

  tdr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  tdr_back #(.BUTTONS(BUTTONS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .window           (window_r),
    .report_en        (report_en_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_id    (out_button_id),
    .out_outcome      (out_outcome),
    .out_sequence_res (out_sequence_res),
    .out_press_tick   (out_press_tick),
    .out_edge_count   (out_edge_count),
    .out_press_count  (out_press_count),
    .out_bounce_count (out_bounce_count)
  );

endmodule

`default_nettype wire
